[rtl/clt_pkg.sv]
// shared types and constants for the climate and light trigger controller
package clt_pkg;

  localparam int unsigned CfgIdxW            = 4;
  localparam int unsigned CfgDataW           = 24;
  localparam int unsigned DefaultIdleTimeout = 15 * 60;
  localparam int unsigned ClimExtW           = 18;
  localparam int unsigned LightExtW          = 26;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_CLIMATE = 2'd1,
    OP_LIGHT   = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_THR     = 4'd0,
    REG_TEMP_HYS     = 4'd1,
    REG_HUMI_THR     = 4'd2,
    REG_HUMI_HYS     = 4'd3,
    REG_LIGHT_THR    = 4'd4,
    REG_LIGHT_HYS    = 4'd5,
    REG_MOTION_HOLD  = 4'd6,
    REG_IDLE_TIMEOUT = 4'd7
  } reg_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] temperature;
    logic               temp_present;
    logic [15:0]        humidity;
    logic               humi_present;
    logic               reed_state;
    logic               reed_present;
    logic [23:0]        illuminance;
    logic               light_present;
    logic               motion_seen;
  } in_t;

  typedef struct packed {
    logic        climate_out;
    logic        temp_alarm;
    logic        humi_alarm;
    logic        dark_alarm;
    logic        light_out;
    logic        reed_out;
    logic [15:0] hold_left;
  } out_t;

  typedef struct packed {
    logic signed [15:0] temp_trip;
    logic signed [15:0] temp_band;
    logic [15:0]        humi_trip;
    logic signed [15:0] humi_band;
    logic [23:0]        light_threshold;
    logic signed [23:0] light_hysteresis;
    logic [15:0]        motion_hold_seconds;
    logic [15:0]        idle_timeout_seconds;
  } cfg_t;

endpackage

[rtl/clt_if.sv]
// handshake channel interfaces for items, results and register writes
interface clt_in_if;
  logic          valid;
  logic          ready;
  clt_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clt_out_if;
  logic          valid;
  logic          ready;
  clt_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [clt_pkg::CfgIdxW-1:0]   idx;
  logic [clt_pkg::CfgDataW-1:0]  wdata;
  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface

[rtl/climate_light_trigger_controller_top.sv]
// top level: input register, event logic and state, result register
// Takes one item (tick, climate sample or light/motion sample) every clock
// cycle and returns exactly one result per item. The state update runs while
// the item sits in the input register, and the result register loads when the
// item advances, so each item passes through the input register and then the
// result register. Throughput is one item per cycle; it drops only when the
// result register is full and not being taken. The result shows the
// detector flags, output levels and motion hold count after that item.
// Register writes are taken every cycle (ready is always high) and must be
// issued only while no item is in flight; writes to indexes above 7 are
// ignored. Idle timeout resets to 900 ticks, all other registers to zero.
module climate_light_trigger_controller_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  clt_in_if.sink     in_i,
  clt_out_if.source  out_o,
  clt_cfg_if.sink    cfg_i
);

  localparam int unsigned CW = clt_pkg::ClimExtW;
  localparam int unsigned LW = clt_pkg::LightExtW;

  clt_pkg::cfg_t regs;
  clt_pkg::in_t  in_q;
  logic          in_valid_q;
  clt_pkg::out_t out_q, out_d;
  logic          out_valid_q;
  logic          advance;

  logic               [15:0] last_temp_q, last_temp_d;
  logic               [15:0] last_humi_q, last_humi_d;
  logic               [23:0] last_light_q, last_light_d;
  logic                      ev_temp_q, ev_humi_q, ev_dark_q;
  logic                      ev_temp_d, ev_humi_d, ev_dark_d;
  logic                      ev_temp_new, ev_humi_new, ev_dark_new;
  logic                      lvl_clim_q, lvl_light_q, lvl_reed_q;
  logic                      lvl_clim_d, lvl_light_d, lvl_reed_d;
  logic               [15:0] hold_q, hold_d;
  logic               [15:0] cidle_q, cidle_d, cidle_inc;
  logic               [15:0] lidle_q, lidle_d, lidle_inc;
  logic                      motion;

  clt_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  // detector inputs use the sample of this item when present
  logic [15:0] temp_sel, humi_sel;
  logic [23:0] light_sel;
  assign temp_sel  = in_q.temp_present  ? in_q.temperature : last_temp_q;
  assign humi_sel  = in_q.humi_present  ? in_q.humidity    : last_humi_q;
  assign light_sel = in_q.light_present ? in_q.illuminance : last_light_q;

  clt_det #(.W(CW)) u_det_temp (
    .ev_i  (ev_temp_q),
    .val_i ($signed({{(CW-16){temp_sel[15]}}, temp_sel})),
    .thr_i ($signed({{(CW-16){regs.temp_trip[15]}}, regs.temp_trip})),
    .hys_i ($signed({{(CW-16){regs.temp_band[15]}}, regs.temp_band})),
    .ev_o  (ev_temp_new)
  );

  clt_det #(.W(CW)) u_det_humi (
    .ev_i  (ev_humi_q),
    .val_i ($signed({{(CW-16){1'b0}}, humi_sel})),
    .thr_i ($signed({{(CW-16){1'b0}}, regs.humi_trip})),
    .hys_i ($signed({{(CW-16){regs.humi_band[15]}}, regs.humi_band})),
    .ev_o  (ev_humi_new)
  );

  clt_det #(.W(LW)) u_det_dark (
    .ev_i  (ev_dark_q),
    .val_i ($signed({{(LW-24){1'b0}}, light_sel})),
    .thr_i ($signed({{(LW-24){1'b0}}, regs.light_threshold})),
    .hys_i ($signed({{(LW-24){regs.light_hysteresis[23]}}, regs.light_hysteresis})),
    .ev_o  (ev_dark_new)
  );

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  assign cidle_inc = (cidle_q != '1) ? cidle_q + 16'd1 : cidle_q;
  assign lidle_inc = (lidle_q != '1) ? lidle_q + 16'd1 : lidle_q;
  assign motion    = in_q.motion_seen && (regs.motion_hold_seconds != '0);

  always_comb begin
    last_temp_d  = last_temp_q;
    last_humi_d  = last_humi_q;
    last_light_d = last_light_q;
    ev_temp_d    = ev_temp_q;
    ev_humi_d    = ev_humi_q;
    ev_dark_d    = ev_dark_q;
    lvl_clim_d   = lvl_clim_q;
    lvl_light_d  = lvl_light_q;
    lvl_reed_d   = lvl_reed_q;
    hold_d       = hold_q;
    cidle_d      = cidle_q;
    lidle_d      = lidle_q;
    unique case (clt_pkg::op_e'(in_q.op))
      clt_pkg::OP_TICK: begin
        if (hold_q != '0) begin
          hold_d = hold_q - 16'd1;
        end
        cidle_d = cidle_inc;
        lidle_d = lidle_inc;
        if (cidle_inc >= regs.idle_timeout_seconds) begin
          lvl_clim_d = 1'b0;
          lvl_reed_d = 1'b0;
          cidle_d    = '0;
        end
        if (lidle_inc >= regs.idle_timeout_seconds) begin
          lvl_light_d = 1'b0;
          lidle_d     = '0;
        end
      end
      clt_pkg::OP_CLIMATE: begin
        last_temp_d = temp_sel;
        last_humi_d = humi_sel;
        ev_temp_d   = ev_temp_new;
        ev_humi_d   = ev_humi_new;
        if (regs.temp_band != '0 || regs.humi_band != '0) begin
          lvl_clim_d = ev_temp_new || ev_humi_new;
        end
        if (in_q.reed_present) begin
          lvl_reed_d = in_q.reed_state;
        end
        cidle_d = '0;
      end
      clt_pkg::OP_LIGHT: begin
        last_light_d = light_sel;
        ev_dark_d    = ev_dark_new;
        if (hold_q != '0) begin
          if (motion) begin
            lvl_light_d = 1'b1;
            hold_d      = regs.motion_hold_seconds;
          end
        end else if (motion) begin
          if (ev_dark_new || regs.light_hysteresis == '0) begin
            lvl_light_d = 1'b1;
            hold_d      = regs.motion_hold_seconds;
          end else begin
            lvl_light_d = 1'b0;
          end
        end else if (regs.motion_hold_seconds != '0) begin
          lvl_light_d = 1'b0;
        end else begin
          lvl_light_d = ev_dark_new;
        end
        lidle_d = '0;
      end
      default: ;
    endcase

    out_d.climate_out = lvl_clim_d;
    out_d.temp_alarm  = ev_temp_d;
    out_d.humi_alarm  = ev_humi_d;
    out_d.dark_alarm  = ev_dark_d;
    out_d.light_out   = lvl_light_d;
    out_d.reed_out    = lvl_reed_d;
    out_d.hold_left   = hold_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_temp_q  <= '0;
      last_humi_q  <= '0;
      last_light_q <= '0;
      ev_temp_q    <= 1'b0;
      ev_humi_q    <= 1'b0;
      ev_dark_q    <= 1'b0;
      lvl_clim_q   <= 1'b0;
      lvl_light_q  <= 1'b0;
      lvl_reed_q   <= 1'b0;
      hold_q       <= '0;
      cidle_q      <= '0;
      lidle_q      <= '0;
    end else if (advance) begin
      last_temp_q  <= last_temp_d;
      last_humi_q  <= last_humi_d;
      last_light_q <= last_light_d;
      ev_temp_q    <= ev_temp_d;
      ev_humi_q    <= ev_humi_d;
      ev_dark_q    <= ev_dark_d;
      lvl_clim_q   <= lvl_clim_d;
      lvl_light_q  <= lvl_light_d;
      lvl_reed_q   <= lvl_reed_d;
      hold_q       <= hold_d;
      cidle_q      <= cidle_d;
      lidle_q      <= lidle_d;
    end
  end

  // idle counters clear before they can rest at saturation
  a_idle_unsat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cidle_q != '1) && (lidle_q != '1))
    else $error("idle counter stuck at saturation");

  // a stalled item stays in the input register
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |=> in_valid_q)
    else $error("stalled item dropped");

  // an accepted item always lands in the input register
  a_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> in_valid_q)
    else $error("accepted item lost");

  // a tick counts the motion hold down by one
  a_tick_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_q.op == clt_pkg::OP_TICK && hold_q != '0)
      |=> hold_q == $past(hold_q) - 16'd1)
    else $error("motion hold not decremented on tick");

endmodule

[rtl/clt_cfg.sv]
// configuration register file
module clt_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  clt_cfg_if.sink       cfg_i,
  output clt_pkg::cfg_t regs_o
);

  clt_pkg::cfg_t regs_q;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q                      <= '0;
      regs_q.idle_timeout_seconds <= 16'(clt_pkg::DefaultIdleTimeout);
    end else if (cfg_i.valid) begin
      unique case (clt_pkg::reg_e'(cfg_i.idx))
        clt_pkg::REG_TEMP_THR:     regs_q.temp_trip            <= cfg_i.wdata[15:0];
        clt_pkg::REG_TEMP_HYS:     regs_q.temp_band            <= cfg_i.wdata[15:0];
        clt_pkg::REG_HUMI_THR:     regs_q.humi_trip            <= cfg_i.wdata[15:0];
        clt_pkg::REG_HUMI_HYS:     regs_q.humi_band            <= cfg_i.wdata[15:0];
        clt_pkg::REG_LIGHT_THR:    regs_q.light_threshold      <= cfg_i.wdata[23:0];
        clt_pkg::REG_LIGHT_HYS:    regs_q.light_hysteresis     <= cfg_i.wdata[23:0];
        clt_pkg::REG_MOTION_HOLD:  regs_q.motion_hold_seconds  <= cfg_i.wdata[15:0];
        clt_pkg::REG_IDLE_TIMEOUT: regs_q.idle_timeout_seconds <= cfg_i.wdata[15:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/clt_det.sv]
// signed hysteresis threshold detector
module clt_det #(
  parameter int unsigned W = clt_pkg::ClimExtW
) (
  input  logic                ev_i,
  input  logic signed [W-1:0] val_i,
  input  logic signed [W-1:0] thr_i,
  input  logic signed [W-1:0] hys_i,
  output logic                ev_o
);

  logic signed [W-1:0] upper;
  logic signed [W-1:0] lower;
  logic                neg;

  assign upper = thr_i + hys_i;
  assign lower = thr_i - hys_i;
  assign neg   = hys_i[W-1];

  always_comb begin
    if (hys_i == '0) begin
      ev_o = 1'b0;
    end else if (ev_i) begin
      // clear when the value leaves the band on the far side
      ev_o = neg ? !(val_i > lower) : !(val_i < lower);
    end else begin
      ev_o = neg ? (val_i < upper) : (val_i > upper);
    end
  end

endmodule
